// ===== sv/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Types and constants shared by the 3x3 RGB box blur modules.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int CFG_W      = 16;
    localparam int WIDTH_W    = 13;
    localparam int CSUM_W     = CH_W + 2;
    localparam int WSUM_W     = CH_W + 4;

    // (x + 4) / 9 as a multiply by ceil(2^16 / 9), exact for x below 2^15
    localparam int RECIP_9     = 7282;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = WSUM_W + RECIP_W;

    // result queue depth, a power of two
    localparam int OFIFO_DEPTH = 8;
    localparam int PTR_W       = $clog2(OFIFO_DEPTH);
    localparam int CNT_W       = $clog2(OFIFO_DEPTH + 1);

    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int MIN_DIM = 3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } bb3_pix_t;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } bb3_colsum_t;

    typedef struct packed {
        logic [WSUM_W-1:0] red;
        logic [WSUM_W-1:0] green;
        logic [WSUM_W-1:0] blue;
    } bb3_wsum_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             frame_end;
    } bb3_meta_t;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             frame_end;
    } bb3_result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bb3_fifo_stat_t;

endpackage

// ===== sv/box_blur_3x3_rgb_top.sv =====
// Path: an accepted pixel passes stage 1, the cell chain and stage 3, then the queue.
// Throughput: one pixel per clock; the input stalls only when the 8-entry result queue,
// counted together with words still in the 3-stage pipeline, is full.
// Reset: clears position counters, pipeline valids and queue; width 640, height 480.
// Line stores are not cleared: no clearing pass, the stream writes every entry it reads.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// 3x3 box filter over a raster RGB stream with two line stores and a cell chain.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top import bb3_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CH_W-1:0]    red_in,
    input  logic [CH_W-1:0]    green_in,
    input  logic [CH_W-1:0]    blue_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ROW_W-1:0]   out_row,
    output logic [COL_W-1:0]   out_col,
    output logic [CH_W-1:0]    red_out,
    output logic [CH_W-1:0]    green_out,
    output logic [CH_W-1:0]    blue_out,
    output logic               frame_end
);

    function automatic logic [CH_W-1:0] div9(input logic [WSUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(RECIP_9);
        return p[RECIP_SHIFT +: CH_W];
    endfunction

    // configuration and position
    logic [COL_W-1:0] last_col_reg;
    logic [ROW_W-1:0] last_row_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             cfg_hit;
    logic [WIDTH_W-1:0] wcfg;
    logic [WIDTH_W-1:0] wsat;
    logic [ROW_W-1:0]   hsat;

    logic             accept;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pop;
    logic             retire;

    bb3_meta_t   meta0;
    bb3_pix_t    px0;

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    bb3_pix_t    px1_reg;
    bb3_meta_t   meta1_reg;
    bb3_meta_t   meta2_reg;
    bb3_meta_t   meta3_reg;
    bb3_wsum_t   sum3_reg;

    logic [PIX_W-1:0] above_rd;
    logic [PIX_W-1:0] above2_rd;
    bb3_pix_t    above;
    bb3_pix_t    above2;
    bb3_colsum_t colsum;

    bb3_colsum_t col_link [3];
    bb3_wsum_t   acc_link [4];

    bb3_result_t    res3;
    logic           push;
    bb3_result_t    head;
    bb3_fifo_stat_t fstat;

    assign cfg_hit = cfg_wr_en &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
    assign wcfg    = cfg_data[WIDTH_W-1:0];

    always_comb
    begin
        wsat = wcfg;
        if (wcfg < WIDTH_W'(MIN_DIM))
        begin
            wsat = WIDTH_W'(MIN_DIM);
        end
        else if (wcfg > WIDTH_W'(MAX_WIDTH))
        begin
            wsat = WIDTH_W'(MAX_WIDTH);
        end
        hsat = cfg_data;
        if (cfg_data < ROW_W'(MIN_DIM))
        begin
            hsat = ROW_W'(MIN_DIM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= COL_W'(639);
            last_row_reg <= ROW_W'(479);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  last_col_reg <= COL_W'(wsat - WIDTH_W'(1));
                REG_IMAGE_HEIGHT: last_row_reg <= hsat - ROW_W'(1);
                default:          ;
            endcase
        end
    end

    assign in_stall = (cnt_reg == CNT_W'(OFIFO_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // words in flight plus words queued; reserves a queue slot per accepted pixel
    assign pop    = out_valid && !out_stall;
    assign retire = v3_reg && !meta3_reg.emit;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = cnt_next + CNT_W'(1);
        end
        if (pop)
        begin
            cnt_next = cnt_next - CNT_W'(1);
        end
        if (retire)
        begin
            cnt_next = cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // stage 0: position tags, line store reads
    assign px0.red         = red_in;
    assign px0.green       = green_in;
    assign px0.blue        = blue_in;
    assign meta0.row       = row_reg - ROW_W'(1);
    assign meta0.col       = col_reg - COL_W'(1);
    assign meta0.emit      = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign meta0.frame_end = (row_reg == last_row_reg) && (col_reg == last_col_reg);

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .clk     (clk),
        .wr_en   (v1_reg),
        .wr_addr (meta1_reg.col + COL_W'(1)),
        .wr_data (px1_reg),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (above_rd)
    );

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .clk     (clk),
        .wr_en   (v1_reg),
        .wr_addr (meta1_reg.col + COL_W'(1)),
        .wr_data (above_rd),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (above2_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px1_reg   <= px0;
            meta1_reg <= meta0;
        end
        if (v1_reg)
        begin
            meta2_reg <= meta1_reg;
        end
        if (v2_reg)
        begin
            meta3_reg      <= meta2_reg;
            sum3_reg.red   <= acc_link[3].red   + WSUM_W'(4);
            sum3_reg.green <= acc_link[3].green + WSUM_W'(4);
            sum3_reg.blue  <= acc_link[3].blue  + WSUM_W'(4);
        end
    end

    // stage 1: column sums enter the window chain
    assign above        = above_rd;
    assign above2       = above2_rd;
    assign colsum.red   = CSUM_W'(px1_reg.red) + CSUM_W'(above.red) + CSUM_W'(above2.red);
    assign colsum.green = CSUM_W'(px1_reg.green) + CSUM_W'(above.green)
                          + CSUM_W'(above2.green);
    assign colsum.blue  = CSUM_W'(px1_reg.blue) + CSUM_W'(above.blue) + CSUM_W'(above2.blue);

    assign acc_link[0] = '0;

    bb3_cell u_cell0 (
        .clk      (clk),
        .shift_en (v1_reg),
        .col_in   (colsum),
        .col_out  (col_link[0]),
        .acc_in   (acc_link[0]),
        .acc_out  (acc_link[1])
    );

    bb3_cell u_cell1 (
        .clk      (clk),
        .shift_en (v1_reg),
        .col_in   (col_link[0]),
        .col_out  (col_link[1]),
        .acc_in   (acc_link[1]),
        .acc_out  (acc_link[2])
    );

    bb3_cell u_cell2 (
        .clk      (clk),
        .shift_en (v1_reg),
        .col_in   (col_link[1]),
        .col_out  (col_link[2]),
        .acc_in   (acc_link[2]),
        .acc_out  (acc_link[3])
    );

    // stage 3: divide by nine, push into the queue
    assign res3.out_row   = meta3_reg.row;
    assign res3.out_col   = meta3_reg.col;
    assign res3.red       = div9(sum3_reg.red);
    assign res3.green     = div9(sum3_reg.green);
    assign res3.blue      = div9(sum3_reg.blue);
    assign res3.frame_end = meta3_reg.frame_end;
    assign push           = v3_reg && meta3_reg.emit;

    bb3_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res3),
        .pop       (pop),
        .head      (head),
        .stat      (fstat)
    );

    assign out_valid = !fstat.empty;
    assign out_row   = head.out_row;
    assign out_col   = head.out_col;
    assign red_out   = head.red;
    assign green_out = head.green;
    assign blue_out  = head.blue;
    assign frame_end = head.frame_end;

    // credit count never exceeds the queue depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(OFIFO_DEPTH))
        else $error("credit count above queue depth");

    // the credit scheme keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && fstat.full && !pop))
        else $error("result queue overflow");

    // position stays inside the configured frame
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= last_col_reg && row_reg <= last_row_reg)
        else $error("position outside frame");

    // a taken pixel reaches the second pipeline stage by way of the first
    a_pipe_timing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 v2_reg)
        else $error("pipeline valid lost");

endmodule

// ===== sv/bb3_ram.sv =====
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bb3_cell.sv =====
// ----------------------------------------------------------------------------
// bb3_cell
// One window column: holds the column sums and adds them to the running sum.
// ----------------------------------------------------------------------------
module bb3_cell import bb3_pkg::*; (
    input  logic        clk,
    input  logic        shift_en,
    input  bb3_colsum_t col_in,
    output bb3_colsum_t col_out,
    input  bb3_wsum_t   acc_in,
    output bb3_wsum_t   acc_out
);

    bb3_colsum_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out       = col_reg;
    assign acc_out.red   = acc_in.red   + WSUM_W'(col_reg.red);
    assign acc_out.green = acc_in.green + WSUM_W'(col_reg.green);
    assign acc_out.blue  = acc_in.blue  + WSUM_W'(col_reg.blue);

endmodule

// ===== sv/bb3_ofifo.sv =====
// ----------------------------------------------------------------------------
// bb3_ofifo
// Small result queue between the filter pipeline and the output channel.
// ----------------------------------------------------------------------------
module bb3_ofifo import bb3_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bb3_result_t    push_data,
    input  logic           pop,
    output bb3_result_t    head,
    output bb3_fifo_stat_t stat
);

    bb3_result_t      mem_reg [OFIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (push && !pop)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - CNT_W'(1);
        end
    end

    // pointers wrap on their own since the depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            occ_reg <= occ_next;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (occ_reg == CNT_W'(OFIFO_DEPTH));
    assign stat.empty = (occ_reg == '0);

endmodule

// ===== tb/tb_box_blur_3x3_rgb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_top
// Streams RGB pixels through the 3x3 box blur under several frame sizes and
// checks every filtered word against a local model of the line stores and
// window. A short directed table runs first, then random pixels with random
// gaps on both sides, a long output hold-off and a stretch at full width.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb_top;
    import bb3_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned WIDTH_RESET   = 640;
    localparam int unsigned HEIGHT_RESET  = 480;

    typedef struct packed {
        bb3_pix_t    px;
        logic        typed;
        bb3_result_t want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CH_W-1:0]    red_in = '0;
    logic [CH_W-1:0]    green_in = '0;
    logic [CH_W-1:0]    blue_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    blue_out;
    logic               frame_end;

    // model state
    bit [PIX_W-1:0]     row_above [MAX_WIDTH];
    bit [PIX_W-1:0]     row_above2 [MAX_WIDTH];
    bit [PIX_W-1:0]     blur_win [9];
    int unsigned        col_pos = 0;
    int unsigned        row_pos = 0;
    logic [WIDTH_W-1:0] width_reg = WIDTH_W'(WIDTH_RESET);
    logic [ROW_W-1:0]   height_reg = ROW_W'(HEIGHT_RESET);

    bb3_result_t        pending_blurs [$];
    stim_row_t          stim_table [$];
    int unsigned        err_count = 0;
    int unsigned        cycle_count = 0;
    int                 send_idle_pct = 23;
    int                 recv_stall_pct = 77;
    int unsigned        hold_tickets = 0;
    int unsigned        hold_served = 0;
    int unsigned        hold_left = 0;

    box_blur_3x3_rgb_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    always #1 clk = ~clk;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic void blur_config(input logic [IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
        case (idx)
            REG_IMAGE_WIDTH:
            begin
                width_reg = data[WIDTH_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            REG_IMAGE_HEIGHT:
            begin
                height_reg = data[ROW_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void blur_predict(input bb3_pix_t px, output bit hit,
                                         output bb3_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        bit [PIX_W-1:0] above;
        bit [PIX_W-1:0] above2;
        bb3_pix_t win_px;
        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < MIN_DIM) h = MIN_DIM;
        c = col_pos;
        r = row_pos;
        above = row_above[c];
        above2 = row_above2[c];
        for (int k = 0; k < 3; k++)
        begin
            blur_win[3 * k] = blur_win[3 * k + 1];
            blur_win[3 * k + 1] = blur_win[3 * k + 2];
        end
        blur_win[2] = above2;
        blur_win[5] = above;
        blur_win[8] = px;
        row_above2[c] = above;
        row_above[c] = px;
        hit = (r >= 2 && c >= 2);
        res = '0;
        if (hit)
        begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int k = 0; k < 9; k++)
            begin
                win_px = blur_win[k];
                sum_r += win_px.red;
                sum_g += win_px.green;
                sum_b += win_px.blue;
            end
            res.out_row = ROW_W'(r - 1);
            res.out_col = COL_W'(c - 1);
            res.red = CH_W'((sum_r + 4) / 9);
            res.green = CH_W'((sum_g + 4) / 9);
            res.blue = CH_W'((sum_b + 4) / 9);
            res.frame_end = (r == h - 1 && c == w - 1);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic void add_stim(input bb3_pix_t px, input logic typed,
                                     input bb3_result_t want);
        stim_row_t row;
        row.px = px;
        row.typed = typed;
        row.want = want;
        stim_table.push_back(row);
    endfunction

    // biased toward the channel extremes
    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    function automatic bb3_pix_t rand_pixel();
        bb3_pix_t px;
        px.red = rand_chan();
        px.green = rand_chan();
        px.blue = rand_chan();
        return px;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        blur_config(idx, data);
        @(negedge clk);
    endtask

    task automatic send_pixel(input bb3_pix_t px, input logic typed, input bb3_result_t want);
        bit hit;
        bb3_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in <= px.red;
        green_in <= px.green;
        blue_in <= px.blue;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        blur_predict(px, hit, res);
        if (typed)
            pending_blurs.push_back(want);
        else if (hit)
            pending_blurs.push_back(res);
        @(negedge clk);
    endtask

    task automatic stream_pixels(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_pixel(rand_pixel(), 1'b0, '0);
    endtask

    // let the pipeline empty before the next register write
    task automatic drain_results();
        int unsigned waited;
        in_valid <= 1'b0;
        waited = 0;
        while (pending_blurs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_blurs.size() != 0)
        begin
            flag_mismatch("words never produced", 0, pending_blurs.size());
            pending_blurs.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // receiver side stall, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_tickets != hold_served)
        begin
            hold_served = hold_tickets;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        bb3_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_blurs.size() == 0)
                flag_mismatch("word with nothing pending, row", out_row, 0);
            else
            begin
                want = pending_blurs.pop_front();
                if (out_row !== want.out_row) flag_mismatch("out_row", out_row, want.out_row);
                if (out_col !== want.out_col) flag_mismatch("out_col", out_col, want.out_col);
                if (red_out !== want.red) flag_mismatch("red_out", red_out, want.red);
                if (green_out !== want.green)
                    flag_mismatch("green_out", green_out, want.green);
                if (blue_out !== want.blue) flag_mismatch("blue_out", blue_out, want.blue);
                if (frame_end !== want.frame_end)
                    flag_mismatch("frame_end", frame_end, want.frame_end);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_box_blur_3x3_rgb_top: errors");
            $finish;
        end
    end

    initial
    begin
        // 3x3 frames: all white, then a rounding check, then a partial frame
        for (int k = 0; k < 8; k++)
            add_stim({8'hff, 8'hff, 8'hff}, 1'b0, '0);
        add_stim({8'hff, 8'hff, 8'hff}, 1'b1,
                 {16'd1, 12'd1, 8'hff, 8'hff, 8'hff, 1'b1});
        add_stim({8'd5, 8'd4, 8'd14}, 1'b0, '0);
        for (int k = 0; k < 7; k++)
            add_stim({8'h00, 8'h00, 8'h00}, 1'b0, '0);
        add_stim({8'h00, 8'h00, 8'h00}, 1'b1,
                 {16'd1, 12'd1, 8'd1, 8'd0, 8'd2, 1'b1});
        add_stim({8'h80, 8'h7f, 8'h01}, 1'b0, '0);
        add_stim({8'hfe, 8'h00, 8'haa}, 1'b0, '0);
        add_stim({8'h55, 8'hff, 8'h0f}, 1'b0, '0);
        add_stim({8'h01, 8'h80, 8'hf0}, 1'b0, '0);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sizes below the minimum saturate to 3x3
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        foreach (stim_table[i])
            send_pixel(stim_table[i].px, stim_table[i].typed, stim_table[i].want);
        drain_results();

        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_WIDTH, 16'd7);
        write_reg(REG_IMAGE_HEIGHT, 16'd5);
        stream_pixels(115);
        drain_results();
        // unused index must not restart the frame
        write_reg(REG_SPARE_2, CFG_W'($urandom));
        stream_pixels(100);
        drain_results();

        send_idle_pct = 77;
        recv_stall_pct = 23;
        write_reg(REG_IMAGE_WIDTH, 16'd16);
        write_reg(REG_IMAGE_HEIGHT, 16'hffff);
        stream_pixels(400);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        hold_tickets++;
        stream_pixels(120);
        drain_results();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        // upper bits dropped, then saturated to the full line length
        write_reg(REG_IMAGE_WIDTH, 16'hffff);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        stream_pixels(200);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(MAX_WIDTH));
        for (int k = 0; k < 3; k++)
        begin
            write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(40, 3)));
            write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(12, 3)));
            write_reg(REG_SPARE_3, CFG_W'($urandom));
            stream_pixels(200);
            drain_results();
        end

        if (err_count == 0)
            $display("tb_box_blur_3x3_rgb_top: clean");
        else
            $display("tb_box_blur_3x3_rgb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bb3_pkg.sv
sv/bb3_ram.sv
sv/bb3_cell.sv
sv/bb3_ofifo.sv
sv/box_blur_3x3_rgb_top.sv
tb/tb_box_blur_3x3_rgb_top.sv
